FILE: sv/meter_teleinfo_line_parser_core_defines.svh
// ----------------------------------------------------------------------------
// meter_teleinfo_line_parser_core_defines
// Assertion helpers for the teleinfo line parser.
// ----------------------------------------------------------------------------
`ifndef METER_TELEINFO_LINE_PARSER_CORE_DEFINES_SVH
`define METER_TELEINFO_LINE_PARSER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define MTLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mtlp_pkg.sv
// ----------------------------------------------------------------------------
// mtlp_pkg
// Types, constants and the label table of the teleinfo line parser.
// ----------------------------------------------------------------------------
package mtlp_pkg;

  localparam int unsigned LineDepthDefault = 64;
  localparam int unsigned NumLabels        = 30;
  localparam int unsigned MaxResults       = 12;
  localparam logic [6:0]  ByteMask         = 7'h7F;

  // register indexes
  localparam logic [2:0] REG_START_FRAME = 3'd0;
  localparam logic [2:0] REG_END_FRAME   = 3'd1;
  localparam logic [2:0] REG_END_DATA    = 3'd2;
  localparam logic [2:0] REG_START_LINE  = 3'd3;
  localparam logic [2:0] REG_END_LINE    = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_NUMBER = 2'd0;
  localparam logic [1:0] KIND_TEXT   = 2'd1;
  localparam logic [1:0] KIND_MARKER = 2'd2;

  typedef enum logic [1:0] {
    CLS_NUM,
    CLS_DIGITS,
    CLS_GRAPH
  } cls_e;

  typedef struct packed {
    logic [55:0] text;   // left aligned, 7 chars of 8 bits
    logic [2:0]  len;
    logic [3:0]  width;
    cls_e        cls;
  } label_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  label_id;
    logic [29:0] number;
    logic [6:0]  text_char;
    logic [3:0]  char_pos;
  } result_t;

  function automatic label_t label_info(input logic [4:0] idx);
    label_t l;
    l = '{text: 56'h0, len: 3'd4, width: 4'd3, cls: CLS_NUM};
    case (idx)
      5'd0:  l = '{{"ADCO", 24'h0},    3'd4, 4'd12, CLS_DIGITS};
      5'd1:  l = '{{"OPTARIF"},        3'd7, 4'd4,  CLS_GRAPH};
      5'd2:  l = '{{"ISOUSC", 8'h0},   3'd6, 4'd2,  CLS_NUM};
      5'd3:  l = '{{"HCHC", 24'h0},    3'd4, 4'd9,  CLS_NUM};
      5'd4:  l = '{{"HCHP", 24'h0},    3'd4, 4'd9,  CLS_NUM};
      5'd5:  l = '{{"EJPHN", 16'h0},   3'd5, 4'd9,  CLS_NUM};
      5'd6:  l = '{{"EJPHPM", 8'h0},   3'd6, 4'd9,  CLS_NUM};
      5'd7:  l = '{{"BBRHCJB"},        3'd7, 4'd9,  CLS_NUM};
      5'd8:  l = '{{"BBRHPJB"},        3'd7, 4'd9,  CLS_NUM};
      5'd9:  l = '{{"BBRHCJW"},        3'd7, 4'd9,  CLS_NUM};
      5'd10: l = '{{"BBRHPJW"},        3'd7, 4'd9,  CLS_NUM};
      5'd11: l = '{{"BBRHCJR"},        3'd7, 4'd9,  CLS_NUM};
      5'd12: l = '{{"BBRHPJR"},        3'd7, 4'd9,  CLS_NUM};
      5'd13: l = '{{"PEJP", 24'h0},    3'd4, 4'd2,  CLS_NUM};
      5'd14: l = '{{"PTEC", 24'h0},    3'd4, 4'd4,  CLS_GRAPH};
      5'd15: l = '{{"DEMAIN", 8'h0},   3'd6, 4'd4,  CLS_GRAPH};
      5'd16: l = '{{"IINST", 16'h0},   3'd5, 4'd3,  CLS_NUM};
      5'd17: l = '{{"IINST1", 8'h0},   3'd6, 4'd3,  CLS_NUM};
      5'd18: l = '{{"IINST2", 8'h0},   3'd6, 4'd3,  CLS_NUM};
      5'd19: l = '{{"IINST3", 8'h0},   3'd6, 4'd3,  CLS_NUM};
      5'd20: l = '{{"ADPS", 24'h0},    3'd4, 4'd3,  CLS_NUM};
      5'd21: l = '{{"ADIR1", 16'h0},   3'd5, 4'd3,  CLS_NUM};
      5'd22: l = '{{"ADIR2", 16'h0},   3'd5, 4'd3,  CLS_NUM};
      5'd23: l = '{{"ADIR3", 16'h0},   3'd5, 4'd3,  CLS_NUM};
      5'd24: l = '{{"IMAX", 24'h0},    3'd4, 4'd3,  CLS_NUM};
      5'd25: l = '{{"IMAX1", 16'h0},   3'd5, 4'd3,  CLS_NUM};
      5'd26: l = '{{"IMAX2", 16'h0},   3'd5, 4'd3,  CLS_NUM};
      5'd27: l = '{{"IMAX3", 16'h0},   3'd5, 4'd3,  CLS_NUM};
      5'd28: l = '{{"PMAX", 24'h0},    3'd4, 4'd5,  CLS_NUM};
      5'd29: l = '{{"PAPP", 24'h0},    3'd4, 4'd5,  CLS_NUM};
      default: l = '{text: 56'h0, len: 3'd4, width: 4'd3, cls: CLS_NUM};
    endcase
    return l;
  endfunction

  function automatic logic [6:0] label_char(input logic [55:0] text, input logic [2:0] k);
    logic [7:0] c;
    c = text[55 - 8 * int'(k) -: 8];
    return c[6:0];
  endfunction

endpackage

FILE: sv/meter_teleinfo_line_parser_core.sv
// ----------------------------------------------------------------------------
// meter_teleinfo_line_parser_core
// Teleinfo line parser: stores line bytes, matches labels at line end and
// emits numeric values, text characters and frame end markers.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  rx_byte_i
//   out      output     out_valid_o / out_stall_i kind, label_id, number,
//                                                text_char, char_pos, last
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// An ordinary byte or a delimiter without marker leaves the parser idle,
// ready for the next byte. A line end scans all 30 labels, reading line
// store characters (label, separator, value; text values read twice) one
// at a time through the single read port of the line store: each is read in
// ST_RD and checked in ST_CHK. A marker passes through ST_MARK and ST_FIN.
// No clearing pass after reset: only entries below the fill count are read.
// Results wait in a hold register and an output register while out is stalled.
// ----------------------------------------------------------------------------
`include "meter_teleinfo_line_parser_core_defines.svh"

module meter_teleinfo_line_parser_core
  import mtlp_pkg::*;
#(
  parameter int unsigned LineDepth = LineDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [4:0]  label_id_o,
  output logic [29:0] number_o,
  output logic [6:0]  text_char_o,
  output logic [3:0]  char_pos_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(LineDepth);
  localparam int unsigned LenW  = $clog2(LineDepth + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LBL  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_MARK = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [6:0] sf_q, ef_q, ed_q, sl_q, el_q;

  logic [2:0]      state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic [4:0]      lbl_q, lbl_d;
  logic [4:0]      k_q, k_d;
  logic            pass_q, pass_d;
  logic [29:0]     acc_q, acc_d;
  logic            mark_q, mark_d;
  logic [3:0]      cnt_q, cnt_d;
  logic            hold_v_q, hold_v_d;
  result_t         hold_q, hold_d;
  logic            out_v_q, out_v_d;
  result_t         out_q, out_d;
  logic            out_last_q, out_last_d;

  logic [6:0] c;
  logic       in_xfer;
  logic       out_free;
  logic       mem_we, mem_re;
  logic [6:0] rdata;
  label_t     lbl;
  logic [4:0] need;
  logic [4:0] pos;
  logic [3:0] digit;
  logic [29:0] acc_next;
  logic       put_req;
  result_t    put_res;
  logic       put_ok;
  logic       is_dig, is_gr, cls_ok;
  logic       fin_done;

  assign c        = rx_byte_i[6:0] & ByteMask;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_v_q || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q <= 7'd2;
      ef_q <= 7'd3;
      ed_q <= 7'd4;
      sl_q <= 7'd10;
      el_q <= 7'd13;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_FRAME: sf_q <= cfg_wdata_i;
        REG_END_FRAME:   ef_q <= cfg_wdata_i;
        REG_END_DATA:    ed_q <= cfg_wdata_i;
        REG_START_LINE:  sl_q <= cfg_wdata_i;
        REG_END_LINE:    el_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign mem_we = in_xfer && !(c == sf_q || c == sl_q || c == ef_q || c == el_q || c == ed_q)
                  && (len_q < LenW'(LineDepth));
  assign mem_re = (state_q == ST_RD);

  mtlp_line_mem #(.LineDepth(LineDepth)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (len_q[AddrW-1:0]),
    .wdata_i (c),
    .re_i    (mem_re),
    .raddr_i (AddrW'(k_q)),
    .rdata_o (rdata)
  );

  assign lbl      = label_info(lbl_q);
  assign need     = 5'(lbl.len) + 5'd1 + 5'(lbl.width);
  assign pos      = k_q - 5'(lbl.len) - 5'd1;
  assign digit    = 4'(rdata - 7'h30);
  assign acc_next = (acc_q << 3) + (acc_q << 1) + 30'(digit);
  assign is_dig   = (rdata >= 7'h30) && (rdata <= 7'h39);
  assign is_gr    = (rdata >= 7'h21) && (rdata <= 7'h7E);
  assign cls_ok   = (lbl.cls == CLS_GRAPH) ? is_gr : is_dig;

  // a result can be taken when the hold slot is free or can move on;
  // past the limit it is dropped
  assign put_ok = !hold_v_q || out_free || (cnt_q >= 4'(MaxResults));

  assign fin_done = (state_q == ST_FIN) && (!hold_v_q || out_free);

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    lbl_d      = lbl_q;
    k_d        = k_q;
    pass_d     = pass_q;
    acc_d      = acc_q;
    mark_d     = mark_q;
    cnt_d      = cnt_q;
    hold_v_d   = hold_v_q;
    hold_d     = hold_q;
    out_v_d    = out_v_q && out_stall_i;
    out_d      = out_q;
    out_last_d = out_last_q;
    put_req    = 1'b0;
    put_res    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          mark_d = (c == ef_q) || (c == ed_q);
          if (c == sf_q || c == sl_q || c == ef_q) begin
            len_d   = '0;
            state_d = mark_d ? ST_MARK : ST_IDLE;
          end else if (c == el_q) begin
            lbl_d   = '0;
            state_d = ST_LBL;
          end else if (c == ed_q) begin
            len_d   = '0;
            state_d = ST_MARK;
          end else if (len_q < LenW'(LineDepth)) begin
            len_d = len_q + 1'b1;
          end
        end
      end
      ST_LBL: begin
        if (lbl_q == 5'(NumLabels)) begin
          state_d = mark_q ? ST_MARK : ST_FIN;
        end else if (LenW'(need) > len_q) begin
          lbl_d = lbl_q + 1'b1;
        end else begin
          k_d     = '0;
          pass_d  = 1'b0;
          acc_d   = '0;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (k_q < 5'(lbl.len)) begin
          if (rdata != label_char(lbl.text, k_q[2:0])) begin
            lbl_d   = lbl_q + 1'b1;
            state_d = ST_LBL;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_RD;
          end
        end else if (k_q == 5'(lbl.len)) begin
          // separator, not checked
          k_d     = k_q + 1'b1;
          state_d = ST_RD;
        end else if (!pass_q) begin
          if (!cls_ok) begin
            lbl_d   = lbl_q + 1'b1;
            state_d = ST_LBL;
          end else if (pos[3:0] != lbl.width - 4'd1) begin
            acc_d   = acc_next;
            k_d     = k_q + 1'b1;
            state_d = ST_RD;
          end else if (lbl.cls == CLS_NUM) begin
            put_req = 1'b1;
            put_res = '{KIND_NUMBER, lbl_q, acc_next, 7'd0, 4'd0};
            if (put_ok) begin
              lbl_d   = lbl_q + 1'b1;
              state_d = ST_LBL;
            end
          end else begin
            // all characters pass, go back and emit them
            pass_d  = 1'b1;
            k_d     = 5'(lbl.len) + 5'd1;
            state_d = ST_RD;
          end
        end else begin
          put_req = 1'b1;
          put_res = '{KIND_TEXT, lbl_q, 30'd0, rdata, pos[3:0]};
          if (put_ok) begin
            if (pos[3:0] == lbl.width - 4'd1) begin
              lbl_d   = lbl_q + 1'b1;
              state_d = ST_LBL;
            end else begin
              k_d     = k_q + 1'b1;
              state_d = ST_RD;
            end
          end
        end
      end
      ST_MARK: begin
        put_req = 1'b1;
        put_res = '{KIND_MARKER, 5'd0, 30'd0, 7'd0, 4'd0};
        if (put_ok) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!hold_v_q || out_free) begin
          if (hold_v_q) begin
            out_v_d    = 1'b1;
            out_d      = hold_q;
            out_last_d = 1'b1;
          end
          hold_v_d = 1'b0;
          cnt_d    = '0;
          len_d    = '0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (put_req && put_ok && (cnt_q < 4'(MaxResults))) begin
      if (hold_v_q) begin
        out_v_d    = 1'b1;
        out_d      = hold_q;
        out_last_d = 1'b0;
      end
      hold_v_d = 1'b1;
      hold_d   = put_res;
      cnt_d    = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      len_q    <= '0;
      lbl_q    <= '0;
      k_q      <= '0;
      pass_q   <= 1'b0;
      mark_q   <= 1'b0;
      cnt_q    <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      lbl_q    <= lbl_d;
      k_q      <= k_d;
      pass_q   <= pass_d;
      mark_q   <= mark_d;
      cnt_q    <= cnt_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_v_q;
  assign kind_o      = out_q.kind;
  assign label_id_o  = out_q.label_id;
  assign number_o    = out_q.number;
  assign text_char_o = out_q.text_char;
  assign char_pos_o  = out_q.char_pos;
  assign last_o      = out_last_q;

  `MTLP_ASSERT_NOW(a_cnt_limit, 1'b1, cnt_q <= 4'(MaxResults), "result count over limit")
  `MTLP_ASSERT_NOW(a_idle_clean, state_q == ST_IDLE, !hold_v_q && cnt_q == 4'd0, "idle busy")
  `MTLP_ASSERT_NOW(a_marker_last, out_v_q && out_q.kind == KIND_MARKER, out_last_q, "marker last")
  `MTLP_ASSERT_NEXT(a_fin_idle, fin_done, state_q == ST_IDLE && len_q == '0, "line not cleared")

endmodule

FILE: sv/mtlp_line_mem.sv
// ----------------------------------------------------------------------------
// mtlp_line_mem
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mtlp_line_mem
  import mtlp_pkg::*;
#(
  parameter int unsigned LineDepth = LineDepthDefault,
  localparam int unsigned AddrW    = $clog2(LineDepth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [6:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [6:0]       rdata_o
);

  logic [6:0] mem_q [LineDepth];
  logic [6:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the teleinfo line parser: sends byte streams built
// from labeled lines and noise, predicts every result and compares each
// output transfer field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import mtlp_pkg::*;

  localparam int CycleLimit = 600000;

  typedef struct {
    string       name;
    int          width;
    cls_e        cls;
  } tag_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  label_id;
    logic [29:0] number;
    logic [6:0]  text_char;
    logic [3:0]  char_pos;
    logic        last;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [4:0]  label_id_o;
  logic [29:0] number_o;
  logic [6:0]  text_char_o;
  logic [3:0]  char_pos_o;
  logic        last_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [6:0]  cfg_wdata_i;

  meter_teleinfo_line_parser_core dut (.*);

  tag_t       tags [NumLabels];
  logic [6:0] codes [5];
  logic [6:0] line_buf [$];
  outcome_t   pending [$];
  int         send_idle_pct;
  int         recv_idle_pct;
  bit         hold_off;
  int         mismatches = 0;
  int         cycles = 0;
  int         seen = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    tags = '{'{"ADCO", 12, CLS_DIGITS}, '{"OPTARIF", 4, CLS_GRAPH},
             '{"ISOUSC", 2, CLS_NUM}, '{"HCHC", 9, CLS_NUM}, '{"HCHP", 9, CLS_NUM},
             '{"EJPHN", 9, CLS_NUM}, '{"EJPHPM", 9, CLS_NUM}, '{"BBRHCJB", 9, CLS_NUM},
             '{"BBRHPJB", 9, CLS_NUM}, '{"BBRHCJW", 9, CLS_NUM},
             '{"BBRHPJW", 9, CLS_NUM}, '{"BBRHCJR", 9, CLS_NUM},
             '{"BBRHPJR", 9, CLS_NUM}, '{"PEJP", 2, CLS_NUM}, '{"PTEC", 4, CLS_GRAPH},
             '{"DEMAIN", 4, CLS_GRAPH}, '{"IINST", 3, CLS_NUM}, '{"IINST1", 3, CLS_NUM},
             '{"IINST2", 3, CLS_NUM}, '{"IINST3", 3, CLS_NUM}, '{"ADPS", 3, CLS_NUM},
             '{"ADIR1", 3, CLS_NUM}, '{"ADIR2", 3, CLS_NUM}, '{"ADIR3", 3, CLS_NUM},
             '{"IMAX", 3, CLS_NUM}, '{"IMAX1", 3, CLS_NUM}, '{"IMAX2", 3, CLS_NUM},
             '{"IMAX3", 3, CLS_NUM}, '{"PMAX", 5, CLS_NUM}, '{"PAPP", 5, CLS_NUM}};
  end

  function automatic void add_result(ref outcome_t res [$], input logic [1:0] kind,
                                     input int id, input int num, input int ch,
                                     input int pos);
    outcome_t r;
    if (res.size() >= MaxResults) return;
    r = '{kind, id[4:0], num[29:0], ch[6:0], pos[3:0], 1'b0};
    res.push_back(r);
  endfunction

  // label scan over the stored line
  function automatic void decode_labels(ref outcome_t res [$]);
    int  start;
    int  value;
    bit  ok;
    byte c;
    for (int i = 0; i < NumLabels; i++) begin
      start = tags[i].name.len() + 1;
      if (start + tags[i].width > line_buf.size()) continue;
      ok = 1;
      for (int k = 0; k < tags[i].name.len(); k++)
        if (line_buf[k] != 7'(tags[i].name[k])) ok = 0;
      for (int k = 0; k < tags[i].width && ok; k++) begin
        c = line_buf[start + k];
        if (tags[i].cls == CLS_GRAPH) ok = (c >= 8'h21 && c <= 8'h7E);
        else ok = (c >= 8'h30 && c <= 8'h39);
      end
      if (!ok) continue;
      if (tags[i].cls == CLS_NUM) begin
        value = 0;
        for (int k = 0; k < tags[i].width; k++)
          value = value * 10 + (line_buf[start + k] - 8'h30);
        add_result(res, KIND_NUMBER, i, value, 0, 0);
      end else begin
        for (int k = 0; k < tags[i].width; k++)
          add_result(res, KIND_TEXT, i, 0, line_buf[start + k], k);
      end
    end
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    outcome_t   res [$];
    logic [6:0] c;
    c = b[6:0];
    if (c == codes[REG_START_FRAME] || c == codes[REG_START_LINE] ||
        c == codes[REG_END_FRAME]) begin
      line_buf.delete();
    end else if (c == codes[REG_END_LINE]) begin
      decode_labels(res);
      line_buf.delete();
    end else if (c == codes[REG_END_DATA]) begin
      line_buf.delete();
    end else if (line_buf.size() < LineDepthDefault) begin
      line_buf.push_back(c);
    end
    if (c == codes[REG_END_FRAME] || c == codes[REG_END_DATA])
      add_result(res, KIND_MARKER, 0, 0, 0, 0);
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending.push_back(res[i]);
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(b);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // receiver idling, sampled at the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && (hold_off || ($urandom_range(99) < recv_idle_pct));
  end

  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{kind_o, label_id_o, number_o, text_char_o, char_pos_o, last_o};
      seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %p", got);
      end else begin
        want = pending.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
        end
      end
    end
  end

  task automatic write_code(input logic [2:0] idx, input logic [6:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    codes[idx]   = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string random_value(input int idx);
    string s;
    s = "";
    for (int k = 0; k < tags[idx].width; k++) begin
      if (tags[idx].cls == CLS_GRAPH) s = {s, string'(byte'($urandom_range(33, 126)))};
      else s = {s, string'(byte'($urandom_range(48, 57)))};
    end
    return s;
  endfunction

  // one information line, mostly well formed
  task automatic send_line();
    int    idx;
    string v;
    idx = $urandom_range(NumLabels - 1);
    v = random_value(idx);
    if ($urandom_range(9) == 0) v[$urandom_range(v.len() - 1)] = byte'($urandom_range(255));
    if ($urandom_range(14) == 0) v = v.substr(0, v.len() - 2);
    send_byte({1'($urandom_range(1)), codes[REG_START_LINE]});
    send_text({tags[idx].name, " ", v, " X"});
    send_byte({1'($urandom_range(1)), codes[REG_END_LINE]});
  endtask

  task automatic send_frame(input int lines);
    send_byte({1'b0, codes[REG_START_FRAME]});
    for (int i = 0; i < lines; i++) send_line();
    if ($urandom_range(7) == 0) send_byte({1'b0, codes[REG_END_DATA]});
    else send_byte({1'b0, codes[REG_END_FRAME]});
  endtask

  task automatic test_directed();
    send_frame(0);
    send_text("\nADCO 012345678901 A\r");
    send_text("\nOPTARIF HC.. <\r");
    send_text("\nIINST1 999 J\r");
    send_text("\nPAPP 0123\r");        // value runs past the line
    send_text("\nHCHC 99999999Z \r");  // bad digit
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h83);                  // end frame with top bit set
    send_byte(8'h04);
    drain();
  endtask

  task automatic test_overflow();
    send_byte({1'b0, codes[REG_START_LINE]});
    send_text("ISOUSC 45 ");
    for (int i = 0; i < 56; i++) send_byte(8'($urandom_range(32, 126)));
    send_byte({1'b0, codes[REG_END_LINE]});
    drain();
  endtask

  task automatic test_random(input int n_frames);
    for (int f = 0; f < n_frames; f++) begin
      if ($urandom_range(4) == 0) send_byte(8'($urandom_range(255)));
      else send_frame($urandom_range(1, 2));
    end
    drain();
  endtask

  task automatic test_codes();
    write_code(REG_START_FRAME, 7'h7F);
    write_code(REG_END_FRAME, 7'h00);
    write_code(REG_END_DATA, 7'h7E);
    write_code(REG_START_LINE, 7'h01);
    write_code(REG_END_LINE, 7'h0A);
    test_random(1);
    // coinciding codes exercise the priority order
    write_code(REG_END_FRAME, 7'h0A);
    write_code(REG_END_DATA, 7'h0A);
    send_text("\nIMAX 090 \n");
    drain();
    write_code(REG_START_FRAME, 7'd2);
    write_code(REG_END_FRAME, 7'd3);
    write_code(REG_END_DATA, 7'd4);
    write_code(REG_START_LINE, 7'd10);
    write_code(REG_END_LINE, 7'd13);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      test_random(2);
    join
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    hold_off    = 0;
    codes       = '{7'd2, 7'd3, 7'd4, 7'd10, 7'd13};
    send_idle_pct = 34;
    recv_idle_pct = 57;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_overflow();
    test_codes();
    send_idle_pct = 57;
    recv_idle_pct = 34;
    test_backpressure();
    test_random(1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(1);
    if (mismatches == 0 && pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
